// ===== rtl/core/best_offset_prefetcher_defines.svh =====
// Assertion macros for the prefetcher RTL.
`ifndef BEST_OFFSET_PREFETCHER_DEFINES_SVH
`define BEST_OFFSET_PREFETCHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BOP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bop_pkg.sv =====
package bop_pkg;

  localparam int unsigned ADDR_W    = 58;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned OUT_OFS_W = 6;
  localparam int unsigned KEY_W     = 20;
  localparam int unsigned SCORE_W   = 8;
  localparam int unsigned ROUND_W   = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_LIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SCORE = 2'd2;

  localparam logic [CFG_W-1:0] SCORE_LIM_RST = 8'd31;
  localparam logic [CFG_W-1:0] ROUND_LIM_RST = 8'd100;
  localparam logic [CFG_W-1:0] LOW_SCORE_RST = 8'd1;

  typedef struct packed {
    logic [CFG_W-1:0] score_lim;
    logic [CFG_W-1:0] round_lim;
    logic [CFG_W-1:0] low_score;
  } bop_cfg_t;

  typedef struct packed {
    logic fire;
    logic hit;
    logic round_end;
  } bop_step_t;

  // True when n has no prime factor above 5 (n below 256).
  function automatic bit is_smooth(int unsigned n);
    int unsigned v;
    v = n;
    for (int j = 0; j < 8; j++) if (v % 2 == 0) v = v / 2;
    for (int j = 0; j < 6; j++) if (v % 3 == 0) v = v / 3;
    for (int j = 0; j < 4; j++) if (v % 5 == 0) v = v / 5;
    return v == 1;
  endfunction

  function automatic int unsigned cand_num(int unsigned page);
    int unsigned c;
    c = 0;
    for (int unsigned i = 1; i < page; i++) if (is_smooth(i)) c++;
    return c;
  endfunction

  function automatic int unsigned cand_at(int unsigned page, int unsigned k);
    int unsigned c;
    int unsigned r;
    c = 0;
    r = 1;
    for (int unsigned i = 1; i < page; i++) begin
      if (is_smooth(i)) begin
        if (c == k) r = i;
        c++;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bop_ram.sv =====
module bop_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bop_score.sv =====
module bop_score #(
  parameter int unsigned NCAND = 26,
  parameter int unsigned OFS_W = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bop_pkg::bop_step_t       step_i,
  input  logic [$clog2(NCAND)-1:0] ptr_i,
  input  logic [OFS_W-1:0]         cd_i,
  input  bop_pkg::bop_cfg_t        cfg_i,
  output logic [OFS_W-1:0]         ofs_cur_o,
  output logic [OFS_W-1:0]         ofs_nxt_o
);

  import bop_pkg::*;

  localparam int unsigned PTR_W = $clog2(NCAND);

  logic [SCORE_W-1:0] score_r [NCAND];
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [OFS_W-1:0]   lbest_r, lbest_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;
  logic [SCORE_W-1:0] sc_cur, sc_inc;
  logic               wipe;

  always_comb begin
    sc_cur    = score_r[ptr_i];
    sc_inc    = (sc_cur != '1) ? sc_cur + 1'b1 : sc_cur;
    best_nxt  = best_r;
    lbest_nxt = lbest_r;
    rnd_nxt   = rnd_r;
    ofs_nxt   = ofs_r;
    wipe      = 1'b0;
    if (step_i.hit && sc_inc > best_r) begin
      best_nxt  = sc_inc;
      lbest_nxt = cd_i;
    end
    if (step_i.round_end) begin
      rnd_nxt = rnd_r + 1'b1;
      if (best_nxt >= cfg_i.score_lim || rnd_nxt == cfg_i.round_lim) begin
        ofs_nxt   = (best_nxt <= cfg_i.low_score) ? '0 : lbest_nxt;
        wipe      = 1'b1;
        best_nxt  = '0;
        lbest_nxt = '0;
        rnd_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      lbest_r <= '0;
      rnd_r   <= '0;
      ofs_r   <= OFS_W'(1);
      for (int k = 0; k < NCAND; k++) begin
        score_r[k] <= '0;
      end
    end else if (step_i.fire) begin
      best_r  <= best_nxt;
      lbest_r <= lbest_nxt;
      rnd_r   <= rnd_nxt;
      ofs_r   <= ofs_nxt;
      for (int k = 0; k < NCAND; k++) begin
        if (wipe) begin
          score_r[k] <= '0;
        end else if (step_i.hit && PTR_W'(k) == ptr_i) begin
          score_r[k] <= sc_inc;
        end
      end
    end
  end

  assign ofs_cur_o = ofs_r;
  assign ofs_nxt_o = ofs_nxt;

endmodule

// ===== rtl/core/best_offset_prefetcher.sv =====
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tdata[57:0] block_addr
// out_    | out | out_tvalid/tready  | tdata[57:0] pf_block, [63:58] learned_offset;
//         |     |                    | tuser pf_valid
// cfg_    | in  | cfg_valid/ready    | cfg_index register, cfg_data value
//
// One item per cycle while out_tready stays high and no clearing pass runs; out_tvalid rises once the
// input transaction has passed the stage 1, 2 and 3 registers and the output register (hash, quotient,
// recent-requests RAM read, score update into the output register). After reset a clearing pass writes
// every recent-requests entry with in_tready low; configuration writes are taken throughout.
// With out_tready low the output register holds and up to three more items are
// taken before in_tready drops.
`include "best_offset_prefetcher_defines.svh"

module best_offset_prefetcher #(
  parameter int unsigned BLOCKS_PER_PAGE = 64,
  parameter int unsigned RR_ENTRIES      = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bop_pkg::DATA_W-1:0]      in_tdata,   // [57:0] block_addr
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bop_pkg::DATA_W-1:0]      out_tdata,  // [57:0] pf_block, [63:58] learned_offset
  output logic                            out_tuser,  // [0] pf_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bop_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bop_pkg::CFG_W-1:0]       cfg_data
);

  import bop_pkg::*;

  localparam int unsigned PG_W  = $clog2(BLOCKS_PER_PAGE);
  localparam int unsigned NCAND = cand_num(BLOCKS_PER_PAGE);
  localparam int unsigned PTR_W = $clog2(NCAND);
  localparam int unsigned IDX_W = $clog2(RR_ENTRIES);
  localparam int unsigned HW    = $clog2(RR_ENTRIES + 1) - 1;
  localparam int unsigned TAG_W = KEY_W - HW;

  // key / RR_ENTRIES by reciprocal
  localparam int unsigned    SH   = KEY_W + IDX_W;
  localparam int unsigned    MW   = KEY_W + 2;
  localparam longint unsigned RR_M =
    ((64'd1 << SH) + RR_ENTRIES - 1) / RR_ENTRIES;

  // page offset: fold the address in 16-bit chunks, then reduce
  localparam int unsigned    SW   = 16 + PG_W + 2;
  localparam int unsigned    SHP  = SW + PG_W;
  localparam int unsigned    MPW  = SW + 2;
  localparam int unsigned    QPW  = SW - PG_W + 1;
  localparam longint unsigned PG_M =
    ((64'd1 << SHP) + BLOCKS_PER_PAGE - 1) / BLOCKS_PER_PAGE;
  localparam logic [PG_W-1:0] PR1 = PG_W'((64'd1 << 16) % BLOCKS_PER_PAGE);
  localparam logic [PG_W-1:0] PR2 = PG_W'((64'd1 << 32) % BLOCKS_PER_PAGE);
  localparam logic [PG_W-1:0] PR3 = PG_W'((64'd1 << 48) % BLOCKS_PER_PAGE);

  // configuration
  logic [CFG_W-1:0] score_lim_r, round_lim_r, low_score_r;
  bop_cfg_t         cfg_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_lim_r <= SCORE_LIM_RST;
      round_lim_r <= ROUND_LIM_RST;
      low_score_r <= LOW_SCORE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCORE_LIM: score_lim_r <= cfg_data;
        REG_ROUND_LIM: round_lim_r <= cfg_data;
        REG_LOW_SCORE: low_score_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready       = 1'b1;
  assign cfg_s.score_lim = score_lim_r;
  assign cfg_s.round_lim = round_lim_r;
  assign cfg_s.low_score = low_score_r;

  // candidate offsets
  logic [PG_W-1:0] cand_tab [NCAND];

  for (genvar g = 0; g < NCAND; g++) begin : g_cand
    assign cand_tab[g] = PG_W'(cand_at(BLOCKS_PER_PAGE, g));
  end

  // flow control
  logic v1_r, v2_r, v3_r;
  logic o_ld, r1, r2, r3, acc;
  logic clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic out_tvalid_r;

  assign o_ld      = !out_tvalid_r || out_tready;
  assign r3        = !v3_r || o_ld;
  assign r2        = !v2_r || r3;
  assign r1        = !v1_r || r2;
  assign in_tready = r1 && !clr_busy_r;
  assign acc       = in_tvalid && in_tready;

  // intake: hash the access and the tested address
  logic [PTR_W-1:0]  ptr_r;
  logic              wrap_acc;
  logic [ADDR_W-1:0] x_in, y_in;
  logic [PG_W-1:0]   cd_acc;
  logic [KEY_W-1:0]  kx_acc, ky_acc;
  logic [SW-1:0]     s_acc;

  assign x_in     = in_tdata[ADDR_W-1:0];
  assign cd_acc   = cand_tab[ptr_r];
  assign wrap_acc = (ptr_r == PTR_W'(NCAND - 1));
  assign y_in     = x_in - ADDR_W'(cd_acc);
  assign kx_acc   = x_in[KEY_W-1:0] ^ KEY_W'(x_in[HW +: HW]);
  assign ky_acc   = y_in[KEY_W-1:0] ^ KEY_W'(y_in[HW +: HW]);
  assign s_acc    = SW'(x_in[15:0]) + SW'(x_in[31:16]) * SW'(PR1)
                  + SW'(x_in[47:32]) * SW'(PR2) + SW'(x_in[57:48]) * SW'(PR3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (acc) begin
      ptr_r <= wrap_acc ? '0 : ptr_r + 1'b1;
    end
  end

  // stage 1: quotients
  logic [ADDR_W-1:0] s1_x_r;
  logic [PG_W-1:0]   s1_cd_r;
  logic [PTR_W-1:0]  s1_ptr_r;
  logic              s1_wrap_r;
  logic [KEY_W-1:0]  s1_kx_r, s1_ky_r;
  logic [SW-1:0]     s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (r1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_x_r    <= x_in;
      s1_cd_r   <= cd_acc;
      s1_ptr_r  <= ptr_r;
      s1_wrap_r <= wrap_acc;
      s1_kx_r   <= kx_acc;
      s1_ky_r   <= ky_acc;
      s1_s_r    <= s_acc;
    end
  end

  logic [KEY_W+MW-1:0] prod_x, prod_y;
  logic [SW+MPW-1:0]   prod_p;

  assign prod_x = (KEY_W+MW)'(s1_kx_r) * (KEY_W+MW)'(RR_M);
  assign prod_y = (KEY_W+MW)'(s1_ky_r) * (KEY_W+MW)'(RR_M);
  assign prod_p = (SW+MPW)'(s1_s_r) * (SW+MPW)'(PG_M);

  // stage 2: remainders, RAM access
  logic [ADDR_W-1:0] s2_x_r;
  logic [PG_W-1:0]   s2_cd_r;
  logic [PTR_W-1:0]  s2_ptr_r;
  logic              s2_wrap_r;
  logic [KEY_W-1:0]  s2_kx_r, s2_ky_r;
  logic [TAG_W-1:0]  s2_qx_r, s2_qy_r;
  logic [SW-1:0]     s2_s_r;
  logic [QPW-1:0]    s2_qp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (r2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_x_r    <= s1_x_r;
      s2_cd_r   <= s1_cd_r;
      s2_ptr_r  <= s1_ptr_r;
      s2_wrap_r <= s1_wrap_r;
      s2_kx_r   <= s1_kx_r;
      s2_ky_r   <= s1_ky_r;
      s2_qx_r   <= prod_x[SH +: TAG_W];
      s2_qy_r   <= prod_y[SH +: TAG_W];
      s2_s_r    <= s1_s_r;
      s2_qp_r   <= prod_p[SHP +: QPW];
    end
  end

  logic [KEY_W+IDX_W-1:0] qn_x, qn_y;
  logic [KEY_W-1:0]       rem_x, rem_y;
  logic [IDX_W-1:0]       idx_x, idx_y;
  logic [SW-1:0]          qpn, rem_p;
  logic [PG_W-1:0]        pofs2;
  logic                   m2;

  assign qn_x  = (KEY_W+IDX_W)'(s2_qx_r) * (KEY_W+IDX_W)'(RR_ENTRIES);
  assign qn_y  = (KEY_W+IDX_W)'(s2_qy_r) * (KEY_W+IDX_W)'(RR_ENTRIES);
  assign rem_x = s2_kx_r - qn_x[KEY_W-1:0];
  assign rem_y = s2_ky_r - qn_y[KEY_W-1:0];
  assign idx_x = rem_x[IDX_W-1:0];
  assign idx_y = rem_y[IDX_W-1:0];
  assign qpn   = SW'(s2_qp_r) * SW'(BLOCKS_PER_PAGE);
  assign rem_p = s2_s_r - qpn;
  assign pofs2 = rem_p[PG_W-1:0];
  assign m2    = v2_r && r3;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [TAG_W:0]   ram_wdata, ram_rdata;

  assign ram_we    = clr_busy_r || m2;
  assign ram_waddr = clr_busy_r ? clr_idx_r : idx_x;
  assign ram_wdata = clr_busy_r ? '0 : {1'b1, s2_qx_r};

  bop_ram #(
    .WIDTH (TAG_W + 1),
    .DEPTH (RR_ENTRIES)
  ) u_rr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (m2),
    .raddr (idx_y),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(RR_ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // stage 3: hit test, scoring, prefetch
  logic [ADDR_W-1:0] s3_x_r;
  logic [PG_W-1:0]   s3_cd_r;
  logic [PTR_W-1:0]  s3_ptr_r;
  logic              s3_wrap_r;
  logic [PG_W-1:0]   s3_pofs_r;
  logic              s3_inr_r;
  logic              s3_same_r;
  logic [TAG_W-1:0]  s3_qx_r, s3_qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (r3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_x_r    <= s2_x_r;
      s3_cd_r   <= s2_cd_r;
      s3_ptr_r  <= s2_ptr_r;
      s3_wrap_r <= s2_wrap_r;
      s3_pofs_r <= pofs2;
      s3_inr_r  <= (pofs2 >= s2_cd_r);
      s3_same_r <= (idx_x == idx_y);
      s3_qx_r   <= s2_qx_r;
      s3_qy_r   <= s2_qy_r;
    end
  end

  logic      m3, hit3;
  bop_step_t step_s;
  logic [PG_W-1:0] ofs_cur, ofs_nxt;

  // same entry written in the cycle of the read: the RAM returns the old word
  assign hit3 = s3_inr_r && (s3_same_r ? (s3_qx_r == s3_qy_r)
                                       : (ram_rdata[TAG_W] && ram_rdata[TAG_W-1:0] == s3_qy_r));
  assign m3   = v3_r && o_ld;

  assign step_s.fire      = m3;
  assign step_s.hit       = m3 && hit3;
  assign step_s.round_end = m3 && s3_wrap_r;

  bop_score #(
    .NCAND (NCAND),
    .OFS_W (PG_W)
  ) u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step_s),
    .ptr_i     (s3_ptr_r),
    .cd_i      (s3_cd_r),
    .cfg_i     (cfg_s),
    .ofs_cur_o (ofs_cur),
    .ofs_nxt_o (ofs_nxt)
  );

  logic [PG_W:0]           pf_sum;
  logic                    pf_ok;
  logic [PG_W+OUT_OFS_W-1:0] ofs_ext;

  assign pf_sum  = {1'b0, s3_pofs_r} + {1'b0, ofs_cur};
  assign pf_ok   = (ofs_cur != '0) && (pf_sum < (PG_W+1)'(BLOCKS_PER_PAGE));
  assign ofs_ext = (PG_W+OUT_OFS_W)'(ofs_nxt);

  // output register
  logic                 out_pf_r;
  logic [ADDR_W-1:0]    out_block_r;
  logic [OUT_OFS_W-1:0] out_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (o_ld) begin
      out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m3) begin
      out_pf_r    <= pf_ok;
      out_block_r <= pf_ok ? s3_x_r + ADDR_W'(ofs_cur) : '0;
      out_ofs_r   <= ofs_ext[OUT_OFS_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_pf_r;
  assign out_tdata  = {out_ofs_r, out_block_r};

  `BOP_ASSERT_NEXT(a_rd_hold, clk, rst_n, v3_r && !o_ld, $stable(ram_rdata), "RAM word lost while stalled")
  `BOP_ASSERT_NEXT(a_ptr_step, clk, rst_n, acc && !wrap_acc, ptr_r == PTR_W'($past(ptr_r) + 1'b1), "candidate pointer skipped")
  `BOP_ASSERT_SAME(a_clr_full, clk, rst_n, $fell(clr_busy_r), $past(clr_idx_r) == IDX_W'(RR_ENTRIES - 1), "clearing pass ended early")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bop_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PAGE_BLOCKS = 64;
  localparam int RR_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 40;

  typedef struct {
    bit pf_valid;
    logic [ADDR_W-1:0] pf_block;
    logic [OUT_OFS_W-1:0] learned_offset;
  } prefetch_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  best_offset_prefetcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [CFG_W-1:0] score_limit;
  logic [CFG_W-1:0] round_limit;
  logic [CFG_W-1:0] weak_score;
  bit rr_present [RR_DEPTH];
  logic [11:0] rr_tags [RR_DEPTH];
  logic [SCORE_W-1:0] cand_score [PAGE_BLOCKS];
  int unsigned cand_offset [PAGE_BLOCKS];
  int unsigned cand_total;
  int unsigned probe_idx;
  logic [ROUND_W-1:0] rounds_done;
  logic [SCORE_W-1:0] top_score;
  logic [OUT_OFS_W-1:0] top_offset;
  logic [OUT_OFS_W-1:0] active_offset;

  prefetch_t pending_prefetches[$];
  int err_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    prefetch_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_prefetches.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, '0);
      end else begin
        want = pending_prefetches.pop_front();
        if (out_tuser !== want.pf_valid)
          report_mismatch("pf_valid", 64'(out_tuser), 64'(want.pf_valid));
        if (out_tdata[ADDR_W-1:0] !== want.pf_block)
          report_mismatch("pf_block", 64'(out_tdata[ADDR_W-1:0]), 64'(want.pf_block));
        if (out_tdata[DATA_W-1:ADDR_W] !== want.learned_offset)
          report_mismatch("learned_offset", 64'(out_tdata[DATA_W-1:ADDR_W]),
                          64'(want.learned_offset));
      end
    end
  end

  function automatic logic [KEY_W-1:0] rr_key(input logic [ADDR_W-1:0] a);
    return {a[19:8], a[7:0] ^ a[15:8]};
  endfunction

  task automatic reset_predictor();
    int unsigned n;
    score_limit = SCORE_LIM_RST;
    round_limit = ROUND_LIM_RST;
    weak_score = LOW_SCORE_RST;
    for (int i = 0; i < RR_DEPTH; i++) begin
      rr_present[i] = 1'b0;
      rr_tags[i] = '0;
    end
    cand_total = 0;
    for (int unsigned i = 1; i < PAGE_BLOCKS; i++) begin
      n = i;
      while (n % 2 == 0) n = n / 2;
      while (n % 3 == 0) n = n / 3;
      while (n % 5 == 0) n = n / 5;
      if (n == 1) begin
        cand_offset[cand_total] = i;
        cand_total++;
      end
    end
    for (int i = 0; i < PAGE_BLOCKS; i++) cand_score[i] = '0;
    probe_idx = 0;
    rounds_done = '0;
    top_score = '0;
    top_offset = '0;
    active_offset = 6'd1;
  endtask

  function automatic prefetch_t predict_prefetch(input logic [ADDR_W-1:0] x);
    prefetch_t r;
    int unsigned pofs;
    int unsigned d;
    logic [KEY_W-1:0] key;
    pofs = x[5:0];
    r.pf_valid = (active_offset != 0) && (pofs + active_offset < PAGE_BLOCKS);
    r.pf_block = r.pf_valid ? x + ADDR_W'(active_offset) : '0;
    key = rr_key(x);
    rr_present[key[7:0]] = 1'b1;
    rr_tags[key[7:0]] = key[19:8];
    d = cand_offset[probe_idx];
    if (pofs >= d) begin
      key = rr_key(x - ADDR_W'(d));
      if (rr_present[key[7:0]] && rr_tags[key[7:0]] == key[19:8]) begin
        if (cand_score[probe_idx] != 8'hFF) cand_score[probe_idx]++;
        if (cand_score[probe_idx] > top_score) begin
          top_score = cand_score[probe_idx];
          top_offset = d[OUT_OFS_W-1:0];
        end
      end
    end
    probe_idx = (probe_idx + 1) % cand_total;
    if (probe_idx == 0) begin
      rounds_done++;
      if (top_score >= score_limit || rounds_done == round_limit) begin
        active_offset = (top_score <= weak_score) ? '0 : top_offset;
        for (int i = 0; i < PAGE_BLOCKS; i++) cand_score[i] = '0;
        top_offset = '0;
        top_score = '0;
        rounds_done = '0;
      end
    end
    r.learned_offset = active_offset;
    return r;
  endfunction

  task automatic send_item(input logic [ADDR_W-1:0] addr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(DATA_W-ADDR_W){1'b0}}, addr};
    do @(posedge clk); while (!in_tready);
    pending_prefetches.insert(pending_prefetches.size(), predict_prefetch(addr));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_prefetches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCORE_LIM: score_limit = val;
      REG_ROUND_LIM: round_limit = val;
      REG_LOW_SCORE: weak_score = val;
      default: ;
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic run_traffic(input int n_items);
    int sent;
    int len;
    int stride;
    logic [ADDR_W-1:0] a;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        a = rand_addr();
        stride = $urandom_range(1, 12);
        len = $urandom_range(8, 40);
        for (int k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(99) < 4) a = rand_addr();
          send_item(a);
          a = a + ADDR_W'(stride);
          sent++;
        end
      end else begin
        send_item(rand_addr());
        sent++;
      end
    end
  endtask

  task automatic test_field_extremes();
    logic [ADDR_W-1:0] a;
    send_item('0);
    send_item('1);
    send_item({{(ADDR_W-1){1'b1}}, 1'b0});
    send_item({(ADDR_W/2){2'b10}});
    send_item({(ADDR_W/2){2'b01}});
    a = rand_addr();
    a[5:0] = '0;
    for (int k = 0; k < 6; k++) send_item(a + ADDR_W'(k));
    send_item(a + ADDR_W'(63));
  endtask

  task automatic test_offset_off();
    logic [ADDR_W-1:0] a;
    settle();
    write_reg(REG_SCORE_LIM, 8'd0);
    write_reg(REG_LOW_SCORE, 8'hFF);
    a = rand_addr();
    for (int k = 0; k < 26; k++) send_item(a + ADDR_W'(k));
    send_item(a + ADDR_W'(40));
    a = rand_addr();
    a[5:0] = '0;
    send_item(a);
  endtask

  task automatic test_fast_rounds();
    settle();
    write_reg(REG_SCORE_LIM, 8'hFF);
    write_reg(REG_ROUND_LIM, 8'd1);
    write_reg(REG_LOW_SCORE, 8'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_traffic(300);
  endtask

  task automatic test_score_limit();
    settle();
    write_reg(REG_SCORE_LIM, 8'd1);
    write_reg(REG_ROUND_LIM, 8'hFF);
    write_reg(REG_LOW_SCORE, 8'd1);
    send_idle_pct = 69;
    recv_stall_pct = 0;
    run_traffic(300);
  endtask

  task automatic test_round_wrap();
    settle();
    write_reg(REG_SCORE_LIM, 8'd31);
    write_reg(REG_ROUND_LIM, 8'd0);
    write_reg(REG_LOW_SCORE, 8'd2);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    run_traffic(300);
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, CFG_W'($urandom_range(255)));
    write_reg(REG_UNUSED, 8'hFF);
    write_reg(REG_SCORE_LIM, 8'd8);
    write_reg(REG_ROUND_LIM, 8'd4);
    write_reg(REG_LOW_SCORE, 8'd0);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    run_traffic(400);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCORE_LIM;
    cfg_data = '0;
    out_tready = 1'b0;
    err_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_offset_off();
    test_fast_rounds();
    test_score_limit();
    test_round_wrap();
    test_unused_index();
    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_prefetches.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
